// ----- design/kct_pkg.sv -----
// kct_pkg: shared types, constants and op/status codes for keyframe_curve_table.
// No dependencies.
`timescale 1ns / 1ps

package kct_pkg;

  localparam int unsigned MaxKeys = 16;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = IdxW + 1;
  localparam logic [31:0] OneQ16  = 32'h0001_0000;

  typedef enum logic [2:0] {
    OP_SAMPLE  = 3'd0,
    OP_ADD     = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_SET     = 3'd3,
    OP_RESTART = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_IDX = 2'd1,
    ST_LAST    = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ALPHA,
    S_DIV,
    S_MUL,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SORT,
    S_SORT_MOVE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] query_time;
    logic signed [31:0] key_value;
    logic [3:0]         key_index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sampled_value;
    logic [1:0]         status;
    logic [3:0]         placed_index;
    logic [4:0]         count_now;
    logic               is_default;
  } out_t;

endpackage

// ----- design/keyframe_curve_table.sv -----
// keyframe_curve_table: sorted Q16.16 key table with linear sampling.
// Sequencing (accept to out_valid_o): sample runs a key scan, a 48-step restoring
// divide and a multiply; add scans for its slot and shifts keys up, remove shifts keys
// down, set runs an insertion sort (one move/cycle); other ops go straight to the result.
// Throughput: one transaction at a time; in_ready_o is high only in idle.
// The result register holds until taken; a new transaction may enter meanwhile.
// Reset (async, active low): one key (0, 1.0), count 1.
`timescale 1ns / 1ps

module keyframe_curve_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kct_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kct_pkg::out_t   out_data_o
);
  import kct_pkg::*;

  // key storage: registers read at a sequencer-chosen index and its neighbor
  logic signed [31:0] kt_q [MaxKeys];
  logic signed [31:0] kv_q [MaxKeys];
  logic [CntW-1:0]    cnt_q;
  state_e             st_q;
  in_t                in_q;
  logic [CntW-1:0]    i_q;        // scan / move pointer
  logic [CntW-1:0]    j_q;        // sort inner pointer
  logic signed [31:0] ht_q, hv_q; // held key during sort
  logic [47:0]        rem_q;
  logic [47:0]        num_q;
  logic [32:0]        den_q;
  logic [5:0]         step_q;
  logic signed [32:0] delta_q;
  logic signed [31:0] vlo_q;
  logic [31:0]        res_q;
  logic [1:0]         stat_q;
  logic [IdxW-1:0]    plc_q;
  logic               ovld_q;
  out_t               obuf_q;

  logic [IdxW-1:0] ii, jj, lastx;
  assign ii    = i_q[IdxW-1:0];
  assign jj    = j_q[IdxW-1:0];
  assign lastx = IdxW'(cnt_q - CntW'(1));

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ovld_q;
  assign out_data_o  = obuf_q;

  // output register load and drain
  logic out_take, out_load;
  assign out_take = ovld_q && out_ready_i;
  assign out_load = (st_q == S_DONE) && (!ovld_q || out_ready_i);

  // restoring divide step
  logic [48:0] trial;
  assign trial = {rem_q, num_q[47]} - {16'd0, den_q};

  // multiply by alpha (quotient low bits) and truncate toward zero
  logic signed [49:0] prod;
  logic signed [49:0] pabs;
  logic signed [33:0] qt;
  assign prod = delta_q * $signed({1'b0, num_q[15:0]});
  assign pabs = prod[49] ? -prod : prod;
  assign qt   = prod[49] ? -$signed(pabs[49:16]) : $signed(pabs[49:16]);

  // decode of a new transaction: fast answers and first sequencer state
  state_e          acc_st;
  logic [31:0]     acc_res;
  logic [1:0]      acc_stat;
  logic [CntW-1:0] acc_i;

  always_comb begin
    acc_st   = S_DONE;
    acc_res  = '0;
    acc_stat = ST_OK;
    acc_i    = '0;
    case (in_data_i.op)
      OP_SAMPLE: begin
        if (cnt_q < CntW'(2) || in_data_i.query_time <= kt_q[0]) begin
          acc_res = kv_q[0];
        end else if (in_data_i.query_time >= kt_q[lastx]) begin
          acc_res = kv_q[lastx];
        end else begin
          acc_i  = CntW'(1);
          acc_st = S_SCAN;
        end
      end
      OP_ADD: begin
        if (cnt_q >= CntW'(MaxKeys)) acc_stat = ST_FULL;
        else acc_st = S_SCAN;
      end
      OP_REMOVE: begin
        if (CntW'(in_data_i.key_index) >= cnt_q) acc_stat = ST_BAD_IDX;
        else if (cnt_q == CntW'(1)) acc_stat = ST_LAST;
        else begin
          acc_i  = CntW'(in_data_i.key_index);
          acc_st = S_SHIFT_DN;
        end
      end
      OP_SET: begin
        if (CntW'(in_data_i.key_index) >= cnt_q) acc_stat = ST_BAD_IDX;
        else begin
          acc_i  = CntW'(1);
          acc_st = S_SORT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= CntW'(1);
      ovld_q <= 1'b0;
      kt_q[0] <= '0;
      kv_q[0] <= OneQ16;
    end else begin
      if (out_load) ovld_q <= 1'b1;
      else if (out_take) ovld_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            in_q   <= in_data_i;
            res_q  <= acc_res;
            stat_q <= acc_stat;
            plc_q  <= '0;
            i_q    <= acc_i;
            st_q   <= acc_st;
            // set writes the new key ahead of the sort
            if (acc_st == S_SORT) begin
              kt_q[in_data_i.key_index] <= in_data_i.query_time;
              kv_q[in_data_i.key_index] <= in_data_i.key_value;
            end
            if (in_data_i.op == OP_RESTART) begin
              kt_q[0] <= in_data_i.query_time;
              kv_q[0] <= in_data_i.key_value;
              cnt_q   <= CntW'(1);
            end
          end
        end
        // find first key with time > query
        S_SCAN: begin
          if (i_q < cnt_q && kt_q[ii] <= in_q.query_time) i_q <= i_q + CntW'(1);
          else if (in_q.op == OP_ADD) begin
            plc_q <= ii;
            j_q   <= cnt_q;
            st_q  <= S_SHIFT_UP;
          end else st_q <= S_ALPHA;
        end
        // set up alpha divide
        S_ALPHA: begin
          num_q   <= {32'(in_q.query_time - kt_q[ii - IdxW'(1)]), 16'd0};
          den_q   <= 33'($signed({kt_q[ii][31], kt_q[ii]}) -
                         $signed({kt_q[ii - IdxW'(1)][31], kt_q[ii - IdxW'(1)]}));
          rem_q   <= '0;
          step_q  <= 6'd48;
          delta_q <= $signed({kv_q[ii][31], kv_q[ii]}) -
                     $signed({kv_q[ii - IdxW'(1)][31], kv_q[ii - IdxW'(1)]});
          vlo_q   <= kv_q[ii - IdxW'(1)];
          st_q    <= S_DIV;
        end
        S_DIV: begin
          if (!trial[48]) begin
            rem_q <= trial[47:0];
            num_q <= {num_q[46:0], 1'b1};
          end else begin
            rem_q <= {rem_q[46:0], num_q[47]};
            num_q <= {num_q[46:0], 1'b0};
          end
          step_q <= step_q - 6'd1;
          if (step_q == 6'd1) st_q <= S_MUL;
        end
        S_MUL: begin
          st_q  <= S_DONE;
          res_q <= 32'(vlo_q + 32'(qt));
        end
        S_SHIFT_UP: begin
          if (j_q > CntW'(plc_q)) begin
            kt_q[jj] <= kt_q[jj - IdxW'(1)];
            kv_q[jj] <= kv_q[jj - IdxW'(1)];
            j_q <= j_q - CntW'(1);
          end else begin
            kt_q[plc_q] <= in_q.query_time;
            kv_q[plc_q] <= in_q.key_value;
            cnt_q <= cnt_q + CntW'(1);
            st_q  <= S_DONE;
          end
        end
        S_SHIFT_DN: begin
          if (i_q + CntW'(1) < cnt_q) begin
            kt_q[ii] <= kt_q[ii + IdxW'(1)];
            kv_q[ii] <= kv_q[ii + IdxW'(1)];
            i_q <= i_q + CntW'(1);
          end else begin
            cnt_q <= cnt_q - CntW'(1);
            st_q  <= S_DONE;
          end
        end
        // insertion sort: pick up key i, then move it down one slot per cycle
        S_SORT: begin
          if (i_q >= cnt_q) st_q <= S_DONE;
          else begin
            ht_q <= kt_q[ii];
            hv_q <= kv_q[ii];
            j_q  <= i_q;
            st_q <= S_SORT_MOVE;
          end
        end
        S_SORT_MOVE: begin
          if (j_q != '0 && kt_q[jj - IdxW'(1)] > ht_q) begin
            kt_q[jj] <= kt_q[jj - IdxW'(1)];
            kv_q[jj] <= kv_q[jj - IdxW'(1)];
            j_q <= j_q - CntW'(1);
          end else begin
            kt_q[jj] <= ht_q;
            kv_q[jj] <= hv_q;
            i_q  <= i_q + CntW'(1);
            st_q <= S_SORT;
          end
        end
        S_DONE: begin
          if (out_load) begin
            obuf_q.sampled_value <= res_q;
            obuf_q.status        <= stat_q;
            obuf_q.placed_index  <= plc_q;
            obuf_q.count_now     <= cnt_q;
            obuf_q.is_default    <= cnt_q == CntW'(1) && kt_q[0] == '0 && kv_q[0] == OneQ16;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for keyframe_curve_table.
// Depends on kct_pkg and the keyframe_curve_table RTL; has its own key-table predictor.
`timescale 1ns / 1ps

module tb_top;
  import kct_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam logic [2:0]  OpUnused   = 3'd7;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  keyframe_curve_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of the key table
  logic signed [31:0] tbl_time [MaxKeys];
  logic signed [31:0] tbl_val  [MaxKeys];
  int unsigned        tbl_cnt;

  out_t        pending_results[$];
  int unsigned mismatch_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  longint unsigned cycle_cnt;

  function automatic int unsigned first_after(input logic signed [31:0] t);
    int unsigned i;
    i = 0;
    while (i < tbl_cnt && tbl_time[i] <= t) i++;
    return i;
  endfunction

  function automatic logic signed [31:0] interp_at(input logic signed [31:0] t);
    int unsigned hi, lo, last;
    longint dt, off, alpha, delta, prod;
    last = tbl_cnt - 1;
    if (tbl_cnt < 2 || t <= tbl_time[0]) return tbl_val[0];
    if (t >= tbl_time[last]) return tbl_val[last];
    hi = first_after(t);
    if (hi == 0 || hi > last) return tbl_val[last];
    lo = hi - 1;
    dt = longint'(tbl_time[hi]) - longint'(tbl_time[lo]);
    off = longint'(t) - longint'(tbl_time[lo]);
    alpha = 0;
    if (dt > 0 && off >= 0) alpha = (off * 65536) / dt;
    delta = longint'(tbl_val[hi]) - longint'(tbl_val[lo]);
    prod = delta * alpha;
    if (prod < 0) prod = -((-prod) / 65536);
    else prod = prod / 65536;
    return 32'(longint'(tbl_val[lo]) + prod);
  endfunction

  function automatic void resort_by_time();
    int unsigned i, j;
    logic signed [31:0] t, v;
    for (i = 1; i < tbl_cnt; i++) begin
      t = tbl_time[i];
      v = tbl_val[i];
      j = i;
      while (j > 0 && tbl_time[j-1] > t) begin
        tbl_time[j] = tbl_time[j-1];
        tbl_val[j]  = tbl_val[j-1];
        j--;
      end
      tbl_time[j] = t;
      tbl_val[j]  = v;
    end
  endfunction

  function automatic out_t apply_to_table(input in_t req);
    out_t r;
    int unsigned i, p;
    r = '0;
    r.status = ST_OK;
    case (req.op)
      OP_SAMPLE: r.sampled_value = interp_at(req.query_time);
      OP_ADD: begin
        if (tbl_cnt >= MaxKeys) r.status = ST_FULL;
        else begin
          p = first_after(req.query_time);
          for (i = tbl_cnt; i > p; i--) begin
            tbl_time[i] = tbl_time[i-1];
            tbl_val[i]  = tbl_val[i-1];
          end
          tbl_time[p] = req.query_time;
          tbl_val[p]  = req.key_value;
          tbl_cnt++;
          r.placed_index = p[3:0];
        end
      end
      OP_REMOVE: begin
        if (req.key_index >= tbl_cnt) r.status = ST_BAD_IDX;
        else if (tbl_cnt == 1) r.status = ST_LAST;
        else begin
          for (i = req.key_index; i + 1 < tbl_cnt; i++) begin
            tbl_time[i] = tbl_time[i+1];
            tbl_val[i]  = tbl_val[i+1];
          end
          tbl_cnt--;
        end
      end
      OP_SET: begin
        if (req.key_index >= tbl_cnt) r.status = ST_BAD_IDX;
        else begin
          tbl_time[req.key_index] = req.query_time;
          tbl_val[req.key_index]  = req.key_value;
          resort_by_time();
        end
      end
      OP_RESTART: begin
        tbl_time[0] = req.query_time;
        tbl_val[0]  = req.key_value;
        tbl_cnt = 1;
      end
      default: ;
    endcase
    r.count_now  = tbl_cnt[4:0];
    r.is_default = (tbl_cnt == 1 && tbl_time[0] == 0 && tbl_val[0] == OneQ16);
    return r;
  endfunction

  // Send one transaction, honoring the sender idle rate; valid stays up between
  // back-to-back transactions and drops only in idle cycles
  task automatic send_key_op(input logic [2:0] op, input logic signed [31:0] t,
                             input logic signed [31:0] v, input logic [3:0] idx);
    in_t  req;
    out_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req.op = op;
    req.query_time = t;
    req.key_value = v;
    req.key_index = idx;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    exp_r = apply_to_table(req);
    pending_results = {pending_results, exp_r};
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data_o.sampled_value !== exp_r.sampled_value ||
            out_data_o.status !== exp_r.status ||
            out_data_o.placed_index !== exp_r.placed_index ||
            out_data_o.count_now !== exp_r.count_now ||
            out_data_o.is_default !== exp_r.is_default) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_data_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'($urandom_range(8) * 65536) - 32'sd262144;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Directed: extremes, every op, every status code
  task automatic test_directed();
    send_key_op(OP_SAMPLE, 32'sd0, 32'sd0, 4'd0);
    send_key_op(OP_REMOVE, 32'sd0, 32'sd0, 4'd0);           // refuses last key
    send_key_op(OP_REMOVE, 32'sd0, 32'sd0, 4'd15);          // index out of range
    send_key_op(OP_SET, 32'sd0, 32'sd0, 4'd3);              // index out of range
    send_key_op(OP_ADD, 32'sh0004_0000, 32'sh8000_0000, 4'd0);
    send_key_op(OP_ADD, 32'sh0002_0000, 32'sh7fff_ffff, 4'd0);
    send_key_op(OP_ADD, 32'sh0002_0000, 32'sd5, 4'd0);      // equal time goes after
    send_key_op(OP_SAMPLE, 32'sh0001_0000, 32'sd0, 4'd0);
    send_key_op(OP_SAMPLE, 32'sh0003_0001, 32'sd0, 4'd0);
    send_key_op(OP_SAMPLE, 32'sh8000_0000, 32'sd0, 4'd0);
    send_key_op(OP_SAMPLE, 32'sh7fff_ffff, 32'sd0, 4'd0);
    send_key_op(OP_SET, 32'sh8000_0000, 32'sh1234_5678, 4'd3); // re-sort to front
    send_key_op(OP_SAMPLE, 32'sd0, 32'sd0, 4'd0);
    for (int i = 0; i < 13; i++)
      send_key_op(OP_ADD, 32'(i) * 32'sd1000, $urandom, 4'd0); // last one hits full
    send_key_op(OP_REMOVE, 32'sd0, 32'sd0, 4'd15);
    send_key_op(OP_SET, 32'sh7fff_ffff, 32'sd0, 4'd0);
    send_key_op(OP_RESTART, 32'sd0, 32'sh0001_0000, 4'd0);  // back to default
    send_key_op(OpUnused, 32'sd0, 32'sd0, 4'd0);            // unknown op
    send_key_op(OP_RESTART, $urandom, $urandom, 4'hf);
  endtask

  // Random mix, biased to grow and shrink the table through its range
  task automatic test_random(input int unsigned n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: op = OP_SAMPLE;
        7, 8, 9, 10:        op = OP_ADD;
        11, 12, 13:         op = OP_REMOVE;
        14, 15, 16:         op = OP_SET;
        17:                 op = ($urandom_range(3) == 0) ? OP_RESTART : OP_ADD;
        18:                 op = 3'($urandom_range(7));
        default:            op = OP_SAMPLE;
      endcase
      send_key_op(op, rand_word(), rand_word(),
                  ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(tbl_cnt)));
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_key_op(OP_ADD, $urandom, $urandom, 4'd0);
  endtask

  initial begin
    mismatch_cnt = 0;
    cycle_cnt = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < MaxKeys; i++) begin
      tbl_time[i] = '0;
      tbl_val[i] = '0;
    end
    tbl_val[0] = OneQ16;
    tbl_cnt = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(400);
    send_idle_pct = 78;
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    test_random(350);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    test_random(350);

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/kct_pkg.sv
design/keyframe_curve_table.sv
tb/tb_top.sv
